// ===== rtl/sfcb_pkg.sv =====
// Shared types and constants for the serial flow-control buffers.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package sfcb_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int FILL_W    = 9;
    localparam int LVL_W     = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] REQ_LINE_IN  = 3'd0;
    localparam logic [2:0] REQ_MODEM    = 3'd1;
    localparam logic [2:0] REQ_TX_SLOT  = 3'd2;
    localparam logic [2:0] REQ_HOST_WR  = 3'd3;
    localparam logic [2:0] REQ_HOST_RD  = 3'd4;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_XONXOFF = 2'd1;
    localparam logic [1:0] MODE_RTSCTS  = 2'd2;
    localparam logic [1:0] MODE_DTRDSR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE      = 2'd2;

    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;

    localparam logic [LVL_W-1:0] DANGER_RST = 9'd204;
    localparam logic [LVL_W-1:0] SAFE_RST   = 9'd52;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
        logic       cts_level;
        logic       dsr_level;
    } t_req;

    typedef struct packed {
        logic              rx_valid;
        logic [7:0]        rx_byte;
        logic              line_tx_valid;
        logic [7:0]        line_tx_byte;
        logic              rts_level;
        logic              dtr_level;
        logic              rx_overflow;
        logic              write_accepted;
        logic              tx_wanted;
        logic [FILL_W-1:0] rx_fill;
        logic [FILL_W-1:0] tx_fill;
    } t_result;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/sfcb_ctrl.sv =====
// Controller state machine: accepts a transaction and sequences its execution.
// Depends on sfcb_pkg for the command struct.
`default_nettype none

module sfcb_ctrl
    import sfcb_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

`default_nettype wire

// ===== rtl/sfcb_dpath.sv =====
// Datapath: receive and transmit ring memories, pointers, flow state and registers.
// Depends on sfcb_pkg; driven by commands from sfcb_ctrl.
`default_nettype none

module sfcb_dpath
    import sfcb_pkg::*;
#(
    parameter int RING_DEPTH = DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_req                  i_req,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    output logic                  o_done,
    output t_result               o_result
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LVL_W) ? CNT_W : LVL_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(RING_DEPTH);

    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];

    t_req             r_req;
    logic [7:0]       r_rx_rdata;
    logic [7:0]       r_tx_rdata;
    logic [PTR_W-1:0] r_rx_head, n_rx_head;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;
    logic [PTR_W-1:0] r_tx_head, n_tx_head;
    logic [CNT_W-1:0] r_tx_count, n_tx_count;
    logic             r_tx_allowed, n_tx_allowed;
    logic             r_partner, n_partner;
    logic             r_rts, n_rts;
    logic             r_dtr, n_dtr;
    logic [1:0]       r_mode;
    logic [LVL_W-1:0] r_danger;
    logic [LVL_W-1:0] r_safe;
    logic             r_done;
    t_result          r_res, n_res;

    logic             rx_we;
    logic [PTR_W-1:0] rx_waddr;
    logic             tx_we;
    logic [PTR_W-1:0] tx_waddr;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] s);
        logic [PTR_W:0] t;
        t = (s >= DEPTH_SUM) ? (s - DEPTH_SUM) : s;
        return t[PTR_W-1:0];
    endfunction

    always_comb begin
        n_rx_head    = r_rx_head;
        n_rx_count   = r_rx_count;
        n_tx_head    = r_tx_head;
        n_tx_count   = r_tx_count;
        n_tx_allowed = r_tx_allowed;
        n_partner    = r_partner;
        n_rts        = r_rts;
        n_dtr        = r_dtr;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_waddr     = wrap({1'b0, r_rx_head} + {1'b0, r_rx_count[PTR_W-1:0]});
        tx_waddr     = wrap({1'b0, r_tx_head} + {1'b0, r_tx_count[PTR_W-1:0]});
        n_res        = '0;

        case (r_req.req_type)
            REQ_LINE_IN: begin
                if (r_mode == MODE_XONXOFF &&
                    (r_req.data_byte == CH_XON || r_req.data_byte == CH_XOFF)) begin
                    n_tx_allowed = (r_req.data_byte == CH_XON);
                end else if (r_rx_count >= DEPTH_CNT) begin
                    n_res.rx_overflow = 1'b1;
                end else begin
                    rx_we      = 1'b1;
                    n_rx_count = r_rx_count + CNT_W'(1);
                    if (r_partner && (CMP_W'(n_rx_count) > CMP_W'(r_danger))) begin
                        n_partner = 1'b0;
                        case (r_mode)
                            MODE_XONXOFF: begin
                                n_res.line_tx_valid = 1'b1;
                                n_res.line_tx_byte  = CH_XOFF;
                            end
                            MODE_RTSCTS: n_rts = 1'b0;
                            MODE_DTRDSR: n_dtr = 1'b0;
                            default: ;
                        endcase
                    end
                end
            end
            REQ_MODEM: begin
                if (r_mode == MODE_RTSCTS) begin
                    n_tx_allowed = r_req.cts_level;
                end else if (r_mode == MODE_DTRDSR) begin
                    n_tx_allowed = r_req.dsr_level;
                end
            end
            REQ_TX_SLOT: begin
                if (r_tx_allowed && r_tx_count != '0) begin
                    n_res.line_tx_valid = 1'b1;
                    n_res.line_tx_byte  = r_tx_rdata;
                    n_tx_head  = wrap({1'b0, r_tx_head} + (PTR_W + 1)'(1));
                    n_tx_count = r_tx_count - CNT_W'(1);
                end
            end
            REQ_HOST_WR: begin
                if (r_tx_count < DEPTH_CNT) begin
                    tx_we                = 1'b1;
                    n_tx_count           = r_tx_count + CNT_W'(1);
                    n_res.write_accepted = 1'b1;
                end
            end
            REQ_HOST_RD: begin
                if (r_rx_count != '0) begin
                    n_res.rx_valid = 1'b1;
                    n_res.rx_byte  = r_rx_rdata;
                    n_rx_head  = wrap({1'b0, r_rx_head} + (PTR_W + 1)'(1));
                    n_rx_count = r_rx_count - CNT_W'(1);
                end
                if (!r_partner && (CMP_W'(n_rx_count) < CMP_W'(r_safe))) begin
                    n_partner = 1'b1;
                    case (r_mode)
                        MODE_XONXOFF: begin
                            n_res.line_tx_valid = 1'b1;
                            n_res.line_tx_byte  = CH_XON;
                        end
                        MODE_RTSCTS: n_rts = 1'b1;
                        MODE_DTRDSR: n_dtr = 1'b1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        n_res.rts_level = n_rts;
        n_res.dtr_level = n_dtr;
        n_res.tx_wanted = n_tx_allowed && (n_tx_count != '0);
        n_res.rx_fill   = FILL_W'(n_rx_count);
        n_res.tx_fill   = FILL_W'(n_tx_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req      <= i_req;
            r_rx_rdata <= rx_mem[r_rx_head];
            r_tx_rdata <= tx_mem[r_tx_head];
        end
        if (i_cmd.execute && rx_we) begin
            rx_mem[rx_waddr] <= r_req.data_byte;
        end
        if (i_cmd.execute && tx_we) begin
            tx_mem[tx_waddr] <= r_req.data_byte;
        end
        if (i_cmd.execute) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head    <= '0;
            r_rx_count   <= '0;
            r_tx_head    <= '0;
            r_tx_count   <= '0;
            r_tx_allowed <= 1'b1;
            r_partner    <= 1'b1;
            r_rts        <= 1'b1;
            r_dtr        <= 1'b1;
            r_done       <= 1'b0;
            r_mode       <= MODE_NONE;
            r_danger     <= DANGER_RST;
            r_safe       <= SAFE_RST;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_rx_head    <= n_rx_head;
                r_rx_count   <= n_rx_count;
                r_tx_head    <= n_tx_head;
                r_tx_count   <= n_tx_count;
                r_tx_allowed <= n_tx_allowed;
                r_partner    <= n_partner;
                r_rts        <= n_rts;
                r_dtr        <= n_dtr;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLOW_MODE: r_mode   <= i_cfg_data[1:0];
                    CFG_DANGER:    r_danger <= i_cfg_data[LVL_W-1:0];
                    CFG_SAFE:      r_safe   <= i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== rtl/serial_flow_control_buffers_top.sv =====
// Top level of the serial flow-control buffers: controller plus datapath.
// Depends on sfcb_pkg, sfcb_ctrl and sfcb_dpath.
//
// A request transaction (line byte, modem status, transmit slot, host write
// or host read) is taken at a clock edge with start high and busy low.
// The controller then enters its execute state, in which busy is high, for
// the update of the ring pointers, flow state and ring memory. The result
// appears on o_result with o_done high for exactly one cycle; both are
// registered at the end of the execute state, and the result is taken at
// the edge that ends the o_done cycle. A new request may be accepted at that
// same edge; no new request is taken while busy is high, so transactions do
// not overlap. The execute state is needed for the registered ring memory
// read: the head entry is read at the accepting edge and used in execution.
// The receiver cannot stall; every result must be taken when o_done is high.
// Configuration writes through i_cfg_we, i_cfg_idx and i_cfg_data take
// effect at once and are meant for idle periods. Reset, synchronous and
// active low, empties both rings, allows transmit, marks the partner running,
// raises RTS and DTR and loads the default flow mode and levels.
// Ring contents need no clearing pass; only occupied entries are read.
`default_nettype none

module serial_flow_control_buffers_top
    import sfcb_pkg::*;
#(
    parameter int RING_DEPTH = DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  t_req                 i_req,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data,
    output logic                 o_done,
    output t_result              o_result
);

    t_cmd cmd;

    sfcb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    sfcb_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not enter execution");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done && !busy)
        else $error("execution did not produce exactly one result");

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_result.rx_valid, o_result.write_accepted,
                             o_result.rx_overflow}))
        else $error("result reports more than one ring action");
`endif

endmodule

`default_nettype wire
